[hdl/two_address_instruction_executor_top_defines.svh]
// Assertion macros for the instruction executor.
`ifndef TWO_ADDRESS_INSTRUCTION_EXECUTOR_TOP_DEFINES_SVH
`define TWO_ADDRESS_INSTRUCTION_EXECUTOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TAIE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TAIE_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TAIE_ASSERT(lbl, clk, rst_n, prop)
`define TAIE_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[hdl/taie_pkg.sv]
package taie_pkg;
  localparam int unsigned MemDepthDef   = 1024;
  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned NumRegsDef    = 8;
  localparam int unsigned WordBitsDef   = 32;

  localparam logic [4:0] OpMov  = 5'd0;
  localparam logic [4:0] OpAdd  = 5'd1;
  localparam logic [4:0] OpSub  = 5'd2;
  localparam logic [4:0] OpMul  = 5'd3;
  localparam logic [4:0] OpDiv  = 5'd4;
  localparam logic [4:0] OpAnd  = 5'd5;
  localparam logic [4:0] OpOr   = 5'd6;
  localparam logic [4:0] OpXor  = 5'd7;
  localparam logic [4:0] OpXnor = 5'd8;
  localparam logic [4:0] OpInc  = 5'd9;
  localparam logic [4:0] OpDec  = 5'd10;
  localparam logic [4:0] OpPush = 5'd12;
  localparam logic [4:0] OpPop  = 5'd13;
  localparam logic [4:0] OpCmp  = 5'd17;
  localparam logic [4:0] OpTest = 5'd18;
  localparam logic [4:0] OpNot  = 5'd19;
  localparam logic [4:0] OpShl  = 5'd23;
  localparam logic [4:0] OpShr  = 5'd24;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StImmDest  = 3'd1;
  localparam logic [2:0] StBadMode  = 3'd2;
  localparam logic [2:0] StDivZero  = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;
  localparam logic [2:0] StUnderflw = 3'd5;

  localparam logic [1:0] KNone = 2'd0;
  localparam logic [1:0] KReg  = 2'd1;
  localparam logic [1:0] KMem  = 2'd2;
  localparam logic [1:0] KImm  = 2'd3;

  function automatic logic [1:0] dest_kind(input logic [3:0] mode);
    case (mode)
      4'd0, 4'd1, 4'd3, 4'd7: dest_kind = KReg;
      4'd4, 4'd5, 4'd8:       dest_kind = KMem;
      4'd2, 4'd6, 4'd9:       dest_kind = KImm;
      default:                dest_kind = KNone;
    endcase
  endfunction

  function automatic logic [1:0] src_kind(input logic [3:0] mode);
    case (mode)
      4'd0, 4'd2, 4'd5:       src_kind = KReg;
      4'd3:                   src_kind = KMem;
      4'd1, 4'd4, 4'd6:       src_kind = KImm;
      default:                src_kind = KNone;
    endcase
  endfunction

  typedef struct packed {
    logic       start;
    logic       is_signed_div;
  } div_ctrl_t;
endpackage

[hdl/taie_if.sv]
interface taie_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic [3:0]  operand_mode;
  logic signed [31:0] dest_operand;
  logic signed [31:0] src_operand;
  modport source (output valid, func, operand_mode, dest_operand, src_operand, input ready);
  modport sink (input valid, func, operand_mode, dest_operand, src_operand, output ready);
endinterface

interface taie_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        wrote_value;
  logic signed [31:0] result_value;
  logic        zero_flag;
  logic [8:0]  stack_count;
  modport source (output valid, status, wrote_value, result_value, zero_flag, stack_count,
                  input ready);
  modport sink (input valid, status, wrote_value, result_value, zero_flag, stack_count,
                output ready);
endinterface

[hdl/taie_div.sv]
module taie_div import taie_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] num_i,
  input  logic [WordBits-1:0] den_i,
  output logic                done_o,
  output logic [WordBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);
  logic                busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [WordBits-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [WordBits:0]   trial;
  logic [WordBits-1:0] na, nb;

  always_comb begin
    na = num_i[WordBits-1] ? (~num_i + 1'b1) : num_i;
    nb = den_i[WordBits-1] ? (~den_i + 1'b1) : den_i;
    trial = {rem_q, quo_q[WordBits-1]} - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[WordBits-1] ^ den_i[WordBits-1];
      cnt_d  = CntBits'(WordBits);
      quo_d  = na;
      rem_d  = '0;
      den_d  = nb;
    end else if (busy_q) begin
      if (!trial[WordBits]) begin
        rem_d = trial[WordBits-1:0];
        quo_d = {quo_q[WordBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WordBits-2:0], quo_q[WordBits-1]};
        quo_d = {quo_q[WordBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

[hdl/two_address_instruction_executor_top.sv]
// Channel  Direction  Payload
// in_if    sink       func, operand_mode, dest_operand, src_operand
// out_if   source     status, wrote_value, result_value, zero_flag, stack_count
// An item is taken in the idle state, then read, executed and written; its result
// is then offered in the output state. A division waits in the divide state while
// the iterative divider works out the quotient.
// After reset the data memory is cleared one word a cycle, all MEM_DEPTH words,
// before the first item is taken. A stalled result holds the block in its
// output state; the next item is taken only once the result has gone.
`include "two_address_instruction_executor_top_defines.svh"
module two_address_instruction_executor_top import taie_pkg::*; #(
  parameter int unsigned MEM_DEPTH   = MemDepthDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned NUM_REGS    = NumRegsDef,
  parameter int unsigned WORD_BITS   = WordBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  taie_in_if.sink    in_if,
  taie_out_if.source out_if
);
  localparam int unsigned MaBits = $clog2(MEM_DEPTH);
  localparam int unsigned RaBits = $clog2(NUM_REGS);
  localparam int unsigned SaBits = $clog2(STACK_DEPTH);
  localparam int unsigned SfBits = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W = WORD_BITS;

  localparam logic [2:0] SClr = 3'd0, SIdle = 3'd1, SRead = 3'd2, SExec = 3'd3,
                         SDiv = 3'd4, SWrite = 3'd5, SOut = 3'd6;

  logic [2:0] state_q, state_d;
  logic [MaBits-1:0] clr_q;
  logic [4:0] func_q;
  logic [3:0] mode_q;
  logic [31:0] dop_q, sop_q;
  logic [W-1:0] regs_q [NUM_REGS];
  logic [W-1:0] dmem [MEM_DEPTH];
  logic [W-1:0] smem [STACK_DEPTH];
  logic [W-1:0] dmem_rd_q, smem_rd_q;
  logic [SfBits-1:0] fill_q, fill_d;
  logic zf_q, zf_d;
  logic [2:0] status_q, status_d;
  logic wrote_q, wrote_d;
  logic [W-1:0] res_q;
  logic [1:0] dk, sk;
  logic [MaBits-1:0] maddr;
  logic [SaBits-1:0] saddr;
  logic [W-1:0] a, b, r;
  logic [2:0] st;
  logic two_w, one_w, dv_start, dv_done, wr_en;
  logic [W-1:0] dv_quot;
  div_ctrl_t dctl;

  assign dk = dest_kind(mode_q);
  assign sk = src_kind(mode_q);
  assign two_w = (func_q <= OpXnor) || func_q == OpShl || func_q == OpShr;
  assign one_w = func_q == OpInc || func_q == OpDec || func_q == OpPush ||
                 func_q == OpPop || func_q == OpNot;
  assign maddr = (dk == KMem) ? dop_q[MaBits-1:0] : sop_q[MaBits-1:0];
  assign saddr = (func_q == OpPop) ? SaBits'(fill_q - 1'b1) : SaBits'(fill_q);

  always_comb begin
    st = StOk;
    if (two_w || func_q == OpTest) begin
      if (mode_q == 4'd2 || mode_q == 4'd6) st = StImmDest;
      else if (func_q == OpShl || func_q == OpShr) begin
        if (!(mode_q == 4'd0 || mode_q == 4'd1 || mode_q == 4'd4)) st = StBadMode;
      end else if (!(mode_q == 4'd0 || mode_q == 4'd1 || mode_q == 4'd3 || mode_q == 4'd5))
        st = StBadMode;
    end else if (func_q == OpCmp) begin
      if (mode_q == 4'd6) st = StImmDest;
      else if (mode_q > 4'd5 || mode_q == 4'd4) st = StBadMode;
    end else if (one_w) begin
      if (mode_q == 4'd9 && func_q != OpPush) st = StImmDest;
      else if (mode_q != 4'd7 && mode_q != 4'd8) st = StBadMode;
    end
    case (dk)
      KReg:    a = regs_q[dop_q[RaBits-1:0]];
      KMem:    a = dmem_rd_q;
      KImm:    a = dop_q[W-1:0];
      default: a = '0;
    endcase
    case (sk)
      KReg:    b = regs_q[sop_q[RaBits-1:0]];
      KMem:    b = dmem_rd_q;
      KImm:    b = sop_q[W-1:0];
      default: b = '0;
    endcase
  end

  assign dctl.start = (state_q == SExec) && st == StOk && func_q == OpDiv && b != '0;
  assign dctl.is_signed_div = 1'b1;
  assign dv_start = dctl.start && dctl.is_signed_div;

  taie_div #(.WordBits(W)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(a), .den_i(b),
    .done_o(dv_done), .quot_o(dv_quot)
  );

  always_comb begin
    case (func_q)
      OpMov:   r = b;
      OpAdd:   r = a + b;
      OpSub:   r = a - b;
      OpMul:   r = W'(a * b);
      OpAnd:   r = a & b;
      OpOr:    r = a | b;
      OpXor:   r = a ^ b;
      OpXnor:  r = ~(a ^ b);
      OpShl:   r = (b >= W'(W)) ? '0 : (a << b);
      OpShr:   r = (b >= W'(W)) ? '0 : (a >> b);
      OpInc:   r = a + 1'b1;
      OpDec:   r = a - 1'b1;
      OpNot:   r = ~a;
      OpPop:   r = smem_rd_q;
      default: r = '0;
    endcase
  end

  always_comb begin
    status_d = st;
    wrote_d  = 1'b0;
    fill_d   = fill_q;
    zf_d     = zf_q;
    if (st == StOk) begin
      if (func_q == OpCmp) zf_d = (a == b);
      else if (func_q == OpTest) zf_d = ((a & b) == '0);
      else if (func_q == OpDiv && b == '0) status_d = StDivZero;
      else if (two_w) wrote_d = (dk == KReg || dk == KMem);
      else if (func_q == OpPush) begin
        if (fill_q >= SfBits'(STACK_DEPTH)) status_d = StOverflow;
        else fill_d = fill_q + 1'b1;
      end else if (func_q == OpPop) begin
        if (fill_q == '0) status_d = StUnderflw;
        else begin
          fill_d  = fill_q - 1'b1;
          wrote_d = 1'b1;
        end
      end else if (one_w) wrote_d = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SClr:   if (clr_q == MaBits'(MEM_DEPTH - 1)) state_d = SIdle;
      SIdle:  if (in_if.valid) state_d = SRead;
      SRead:  state_d = SExec;
      SExec:  state_d = dv_start ? SDiv : SWrite;
      SDiv:   if (dv_done) state_d = SWrite;
      SWrite: state_d = SOut;
      SOut:   if (out_if.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign wr_en = (state_q == SWrite) && wrote_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      clr_q <= '0;
      fill_q <= '0;
      zf_q <= 1'b0;
      status_q <= StOk;
      wrote_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SClr) clr_q <= clr_q + 1'b1;
      if (state_q == SExec) begin
        status_q <= status_d;
        wrote_q <= wrote_d;
        fill_q <= fill_d;
        zf_q <= zf_d;
      end else if (state_q == SOut && out_if.ready) begin
        wrote_q <= 1'b0;
      end
      if (wr_en && dk == KReg) regs_q[dop_q[RaBits-1:0]] <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_if.valid) begin
      func_q <= in_if.func;
      mode_q <= in_if.operand_mode;
      dop_q  <= in_if.dest_operand;
      sop_q  <= in_if.src_operand;
    end
    if (state_q == SExec) res_q <= r;
    else if (state_q == SDiv && dv_done) res_q <= dv_quot;
    if (state_q == SClr) dmem[clr_q] <= '0;
    else if (wr_en && dk == KMem) dmem[maddr] <= res_q;
    dmem_rd_q <= dmem[maddr];
    if (state_q == SExec && st == StOk && func_q == OpPush && fill_q < SfBits'(STACK_DEPTH))
      smem[saddr] <= a;
    smem_rd_q <= smem[saddr];
  end

  assign in_if.ready = (state_q == SIdle);
  assign out_if.valid = (state_q == SOut);
  assign out_if.status = status_q;
  assign out_if.wrote_value = wrote_q;
  assign out_if.result_value = wrote_q ? 32'(signed'(res_q)) : '0;
  assign out_if.zero_flag = zf_q;
  assign out_if.stack_count = 9'(fill_q);

  `TAIE_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != SIdle) |-> !in_if.ready)
  `TAIE_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= SfBits'(STACK_DEPTH))
  `TAIE_ASSERT(a_wrote_ok, clk_i, rst_ni, out_if.valid && out_if.wrote_value |-> out_if.status == StOk)
  `TAIE_ASSERT(a_div_start, clk_i, rst_ni, dv_start |=> state_q == SDiv)
endmodule

[bench/two_address_instruction_executor_top_tb.sv]
module two_address_instruction_executor_top_tb;
  import taie_pkg::*;

  typedef struct packed {
    logic [4:0]  func;
    logic [3:0]  mode;
    logic [31:0] dop;
    logic [31:0] sop;
  } instr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wrote;
    logic [31:0] res;
    logic        zf;
    logic [8:0]  cnt;
  } outcome_t;

  localparam int NumRandom = 460;

  logic clk_i;
  logic rst_ni;

  taie_in_if  in_if ();
  taie_out_if out_if ();

  two_address_instruction_executor_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic [31:0] regs_m [NumRegsDef];
  logic [31:0] mem_m [MemDepthDef];
  logic [31:0] stack_m [StackDepthDef];
  int unsigned fill_m;
  logic        zf_m;

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  int unsigned issued;
  int unsigned total_items;
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always #4 clk_i = ~clk_i;

  function automatic logic [1:0] kind_of_dest(input logic [3:0] mode);
    case (mode)
      4'd0, 4'd1, 4'd3, 4'd7: return KReg;
      4'd4, 4'd5, 4'd8:       return KMem;
      4'd2, 4'd6, 4'd9:       return KImm;
      default:                return KNone;
    endcase
  endfunction

  function automatic logic [1:0] kind_of_src(input logic [3:0] mode);
    case (mode)
      4'd0, 4'd2, 4'd5: return KReg;
      4'd3:             return KMem;
      4'd1, 4'd4, 4'd6: return KImm;
      default:          return KNone;
    endcase
  endfunction

  function automatic logic [31:0] read_operand(input logic [1:0] k, input logic [31:0] op);
    case (k)
      KReg:    return regs_m[op % NumRegsDef];
      KMem:    return mem_m[op % MemDepthDef];
      KImm:    return op;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic write_operand(input logic [1:0] k, input logic [31:0] op,
                                         input logic [31:0] v);
    if (k == KReg) begin
      regs_m[op % NumRegsDef] = v;
      return 1'b1;
    end
    if (k == KMem) begin
      mem_m[op % MemDepthDef] = v;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t execute(input instr_t t);
    outcome_t o;
    logic [1:0] dk, sk;
    logic [31:0] a, b, r;
    logic two_w, one_w;
    longint x, y;
    o = '0;
    dk = kind_of_dest(t.mode);
    sk = kind_of_src(t.mode);
    r = '0;
    two_w = t.func <= OpXnor || t.func == OpShl || t.func == OpShr;
    one_w = t.func inside {OpInc, OpDec, OpPush, OpPop, OpNot};
    o.status = StOk;
    if (two_w || t.func == OpTest) begin
      if (t.mode == 4'd2 || t.mode == 4'd6) o.status = StImmDest;
      else if (t.func == OpShl || t.func == OpShr) begin
        if (!(t.mode inside {4'd0, 4'd1, 4'd4})) o.status = StBadMode;
      end else if (!(t.mode inside {4'd0, 4'd1, 4'd3, 4'd5})) o.status = StBadMode;
    end else if (t.func == OpCmp) begin
      if (t.mode == 4'd6) o.status = StImmDest;
      else if (!(t.mode inside {4'd0, 4'd1, 4'd2, 4'd3, 4'd5})) o.status = StBadMode;
    end else if (one_w) begin
      if (t.mode == 4'd9 && t.func != OpPush) o.status = StImmDest;
      else if (t.mode != 4'd7 && t.mode != 4'd8) o.status = StBadMode;
    end
    if (o.status == StOk && (two_w || t.func == OpCmp || t.func == OpTest)) begin
      a = read_operand(dk, t.dop);
      b = read_operand(sk, t.sop);
      case (t.func)
        OpMov:  r = b;
        OpAdd:  r = a + b;
        OpSub:  r = a - b;
        OpMul:  r = a * b;
        OpDiv: begin
          if (b == 0) o.status = StDivZero;
          else begin
            x = longint'($signed(a));
            y = longint'($signed(b));
            r = 32'(x / y);
          end
        end
        OpAnd:  r = a & b;
        OpOr:   r = a | b;
        OpXor:  r = a ^ b;
        OpXnor: r = ~(a ^ b);
        OpShl:  r = (b >= 32) ? 32'd0 : a << b[4:0];
        OpShr:  r = (b >= 32) ? 32'd0 : a >> b[4:0];
        OpCmp:  zf_m = (a == b);
        default: zf_m = ((a & b) == 0);
      endcase
      if (o.status == StOk && two_w) begin
        o.wrote = write_operand(dk, t.dop, r);
        if (o.wrote) o.res = r;
      end
    end else if (o.status == StOk && one_w) begin
      a = read_operand(dk, t.dop);
      if (t.func == OpPush) begin
        if (fill_m >= StackDepthDef) o.status = StOverflow;
        else begin
          stack_m[fill_m] = a;
          fill_m++;
        end
      end else begin
        if (t.func == OpPop) begin
          if (fill_m == 0) o.status = StUnderflw;
          else begin
            fill_m--;
            r = stack_m[fill_m];
          end
        end else if (t.func == OpInc) r = a + 1;
        else if (t.func == OpDec) r = a - 1;
        else r = ~a;
        if (o.status == StOk) begin
          o.wrote = write_operand(dk, t.dop, r);
          if (o.wrote) o.res = r;
        end
      end
    end
    o.zf = zf_m;
    o.cnt = fill_m[8:0];
    return o;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'($urandom_range(40));
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t t;
    logic [4:0] ops [18];
    ops = '{OpMov, OpAdd, OpSub, OpMul, OpDiv, OpAnd, OpOr, OpXor, OpXnor, OpInc, OpDec,
            OpPush, OpPop, OpCmp, OpTest, OpNot, OpShl, OpShr};
    t.dop = $urandom();
    t.sop = pick_value();
    if ($urandom_range(99) < 15) begin
      t.func = 5'($urandom());
      t.mode = 4'($urandom());
      t.dop = pick_value();
      return t;
    end
    t.func = ops[$urandom_range(17)];
    case (t.func)
      OpInc, OpDec, OpPush, OpPop, OpNot: t.mode = $urandom_range(1) ? 4'd7 : 4'd8;
      OpShl, OpShr: begin
        case ($urandom_range(2))
          0:       t.mode = 4'd0;
          1:       t.mode = 4'd1;
          default: t.mode = 4'd4;
        endcase
      end
      OpCmp: begin
        t.mode = 4'($urandom_range(5));
        if (t.mode == 4'd4) t.mode = 4'd2;
      end
      default: begin
        case ($urandom_range(3))
          0:       t.mode = 4'd0;
          1:       t.mode = 4'd1;
          2:       t.mode = 4'd3;
          default: t.mode = 4'd5;
        endcase
      end
    endcase
    if (t.func == OpDiv && $urandom_range(9) == 0) t.sop = 32'd0;
    return t;
  endfunction

  task automatic add_instr(input logic [4:0] f, input logic [3:0] m,
                           input logic [31:0] d, input logic [31:0] s);
    pending_instrs.push_back({f, m, d, s});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func <= '0;
      in_if.operand_mode <= '0;
      in_if.dest_operand <= '0;
      in_if.src_operand <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        expected_outcomes.push_back(execute({in_if.func, in_if.operand_mode,
                                             in_if.dest_operand, in_if.src_operand}));
        issued++;
      end
      if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        instr_t t;
        t = pending_instrs.pop_front();
        in_if.valid <= 1'b1;
        in_if.func <= t.func;
        in_if.operand_mode <= t.mode;
        in_if.dest_operand <= t.dop;
        in_if.src_operand <= t.sop;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item, status %0d", out_if.status);
        end else begin
          outcome_t e;
          e = expected_outcomes.pop_front();
          if (out_if.status !== e.status || out_if.wrote_value !== e.wrote ||
              out_if.result_value !== e.res || out_if.zero_flag !== e.zf ||
              out_if.stack_count !== e.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %h %0d %0d, got %0d %0d %h %0d %0d",
                       e.status, e.wrote, e.res, e.zf, e.cnt, out_if.status,
                       out_if.wrote_value, out_if.result_value, out_if.zero_flag,
                       out_if.stack_count);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (total_items != 0) begin
      case (issued * 4 / total_items)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 70;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 70;
        end
        default: begin
          send_idle_pct <= 9;
          recv_stall_pct <= 9;
        end
      endcase
    end
  end

  initial begin
    #(8 * 4000000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    issued = 0;
    total_items = 0;
    mismatches = 0;
    fill_m = 0;
    zf_m = 1'b0;
    foreach (regs_m[i]) regs_m[i] = '0;
    foreach (mem_m[i]) mem_m[i] = '0;
    foreach (stack_m[i]) stack_m[i] = '0;

    add_instr(OpPop, 4'd7, 32'd1, 32'd0);
    add_instr(OpMov, 4'd1, 32'd0, 32'h7fff_ffff);
    add_instr(OpMov, 4'd1, 32'hffff_fff9, 32'h8000_0000);
    add_instr(OpAdd, 4'd1, 32'd0, 32'd1);
    add_instr(OpDiv, 4'd1, 32'd7, 32'hffff_ffff);
    add_instr(OpDiv, 4'd1, 32'd0, 32'd0);
    add_instr(OpSub, 4'd0, 32'd2, 32'd7);
    add_instr(OpMul, 4'd3, 32'd0, 32'd5);
    add_instr(OpAnd, 4'd5, 32'd9, 32'd0);
    add_instr(OpOr, 4'd4, 32'd9, 32'hffff_ffff);
    add_instr(OpXor, 4'd0, 32'd3, 32'd7);
    add_instr(OpXnor, 4'd1, 32'd4, 32'h1234_5678);
    add_instr(OpInc, 4'd8, 32'hffff_ffff, 32'd0);
    add_instr(OpDec, 4'd7, 32'd5, 32'd0);
    add_instr(OpNot, 4'd7, 32'd6, 32'd0);
    add_instr(OpPush, 4'd7, 32'd0, 32'd0);
    add_instr(OpPop, 4'd8, 32'd3, 32'd0);
    add_instr(OpPush, 4'd9, 32'd0, 32'd0);
    add_instr(OpInc, 4'd9, 32'd0, 32'd0);
    add_instr(OpMov, 4'd2, 32'd0, 32'd0);
    add_instr(OpCmp, 4'd6, 32'd1, 32'd1);
    add_instr(OpCmp, 4'd2, 32'h8000_0000, 32'd7);
    add_instr(OpTest, 4'd1, 32'd3, 32'd0);
    add_instr(OpShl, 4'd1, 32'd0, 32'd32);
    add_instr(OpShr, 4'd0, 32'd7, 32'd0);
    add_instr(5'd11, 4'd12, 32'd0, 32'd0);
    add_instr(OpAdd, 4'd15, 32'd0, 32'd0);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 100) begin
        for (int j = 0; j < StackDepthDef + 3; j++)
          add_instr(OpPush, 4'd7, $urandom(), 32'd0);
      end
      if (i == 300) begin
        for (int j = 0; j < StackDepthDef + 3; j++)
          add_instr(OpPop, $urandom_range(1) ? 4'd7 : 4'd8, $urandom(), 32'd0);
      end
      pending_instrs.push_back(random_instr());
    end
    total_items = pending_instrs.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_instrs.size() != 0 || in_if.valid || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
